// ----- design/bpdh_pkg.sv -----
// ----------------------------------------------------------------------------
// bpdh_pkg
// Types and constants shared by the button press, double press and hold
// detector.
// ----------------------------------------------------------------------------
package bpdh_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IDLE_LEVEL    = 3'd0,
    CFG_DEBOUNCE      = 3'd1,
    CFG_FIRST_DELAY   = 3'd2,
    CFG_HOLD_START    = 3'd3,
    CFG_HOLD_REPEAT   = 3'd4,
    CFG_DOUBLE_WINDOW = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_PRESS      = 2'd0,
    EV_DOUBLE     = 2'd1,
    EV_HOLD       = 2'd2,
    EV_HOLD_ACKED = 2'd3
  } event_kind_e;

  typedef enum logic [4:0] {
    PS_PRESS       = 5'b00001,
    PS_DOUBLE      = 5'b00010,
    PS_HOLD        = 5'b00100,
    PS_HOLD_ACKED  = 5'b01000,
    PS_NOT_PRESSED = 5'b10000
  } press_status_e;

  localparam logic [7:0] HoldQuartersMax = 8'hff;
  localparam logic [7:0] FirstHoldQuarters = 8'd3;

  typedef struct packed {
    logic pin_level;
    logic consumer_ack;
  } in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [5:0] hold_seconds;
    logic       is_down;
  } out_t;

  typedef struct packed {
    logic       idle_level;
    logic [6:0] debounce_ticks;
    logic [6:0] first_event_delay;
    logic [6:0] hold_start_delay;
    logic [6:0] hold_repeat_period;
    logic [7:0] double_window;
  } cfg_t;

  typedef struct packed {
    logic [7:0]    debounce_count;
    logic [7:0]    repeat_count;
    logic [7:0]    double_timer;
    logic [7:0]    hold_quarters;
    press_status_e press_status;
    logic          key_down;
    logic          double_armed;
  } st_t;

endpackage

// ----- design/button_press_double_hold_detector_core.sv -----
// ----------------------------------------------------------------------------
// button_press_double_hold_detector_core
// Debounces a button pin one tick item at a time and gives press, double
// press and repeating hold events through a registered output stage.
// ----------------------------------------------------------------------------
// A result is registered and is output in the cycle after its item is accepted.
// Throughput: one item per cycle; the output register stalls input only while
// a held result is not taken.
// Reset: asynchronous, active low; clears all counters, sets the status to not
// pressed and loads the register defaults.
module button_press_double_hold_detector_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpdh_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bpdh_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bpdh_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bpdh_pkg::out_t                      out_data_o
);

  bpdh_pkg::cfg_t cfg_q;
  bpdh_pkg::st_t  st_q, st_d;
  bpdh_pkg::out_t res, out_q;
  logic           res_valid, out_valid_q, accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bpdh_step u_step (
    .cfg_i       (cfg_q),
    .st_i        (st_q),
    .in_i        (in_data_i),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_level         <= 1'b1;
      cfg_q.debounce_ticks     <= 7'd2;
      cfg_q.first_event_delay  <= 7'd5;
      cfg_q.hold_start_delay   <= 7'd100;
      cfg_q.hold_repeat_period <= 7'd25;
      cfg_q.double_window      <= 8'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpdh_pkg::CFG_IDLE_LEVEL:    cfg_q.idle_level         <= cfg_data_i[0];
        bpdh_pkg::CFG_DEBOUNCE:      cfg_q.debounce_ticks     <= cfg_data_i[6:0];
        bpdh_pkg::CFG_FIRST_DELAY:   cfg_q.first_event_delay  <= cfg_data_i[6:0];
        bpdh_pkg::CFG_HOLD_START:    cfg_q.hold_start_delay   <= cfg_data_i[6:0];
        bpdh_pkg::CFG_HOLD_REPEAT:   cfg_q.hold_repeat_period <= cfg_data_i[6:0];
        bpdh_pkg::CFG_DOUBLE_WINDOW: cfg_q.double_window      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.debounce_count <= 8'd0;
      st_q.repeat_count   <= 8'd0;
      st_q.double_timer   <= 8'd0;
      st_q.hold_quarters  <= 8'd0;
      st_q.press_status   <= bpdh_pkg::PS_NOT_PRESSED;
      st_q.key_down       <= 1'b0;
      st_q.double_armed   <= 1'b0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

endmodule

// ----- design/bpdh_step.sv -----
// ----------------------------------------------------------------------------
// bpdh_step
// Next-state and result logic for one tick item of the detector.
// ----------------------------------------------------------------------------
module bpdh_step (
  input  bpdh_pkg::cfg_t cfg_i,
  input  bpdh_pkg::st_t  st_i,
  input  bpdh_pkg::in_t  in_i,
  output bpdh_pkg::st_t  st_o,
  output logic           res_valid_o,
  output bpdh_pkg::out_t res_o
);

  function automatic logic [1:0] kind_of(input bpdh_pkg::press_status_e ps);
    logic [1:0] k;
    case (ps)
      bpdh_pkg::PS_DOUBLE:     k = bpdh_pkg::EV_DOUBLE;
      bpdh_pkg::PS_HOLD:       k = bpdh_pkg::EV_HOLD;
      bpdh_pkg::PS_HOLD_ACKED: k = bpdh_pkg::EV_HOLD_ACKED;
      default:                 k = bpdh_pkg::EV_PRESS;
    endcase
    return k;
  endfunction

  always_comb begin
    bpdh_pkg::st_t s;
    logic          pressed;
    s = st_i;
    res_valid_o = 1'b0;
    res_o = '0;

    if (s.debounce_count[6:0] != 7'd0) s.debounce_count = s.debounce_count - 8'd1;
    if (s.repeat_count[6:0] != 7'd0) s.repeat_count = s.repeat_count - 8'd1;

    if (s.double_timer != 8'd0) begin
      s.double_timer = s.double_timer - 8'd1;
    end else begin
      s.double_armed = 1'b0;
    end

    pressed = (in_i.pin_level != cfg_i.idle_level);
    if (pressed) begin
      if (s.debounce_count == 8'd0) begin
        s.debounce_count = {1'b1, cfg_i.debounce_ticks};
      end else if (s.debounce_count == 8'h80 && !s.key_down) begin
        s.key_down = 1'b1;
        if (!s.double_armed || s.double_timer == 8'd0) begin
          s.double_armed = 1'b1;
          s.press_status = bpdh_pkg::PS_PRESS;
          s.double_timer = cfg_i.double_window;
        end else begin
          s.press_status = bpdh_pkg::PS_DOUBLE;
          s.double_armed = 1'b0;
        end
        s.repeat_count = {1'b0, cfg_i.first_event_delay};
        s.hold_quarters = 8'd0;
      end
    end else if (s.key_down) begin
      s.debounce_count = 8'd0;
      s.repeat_count = 8'd0;
      s.key_down = 1'b0;
      s.press_status = bpdh_pkg::PS_NOT_PRESSED;
    end

    if (s.key_down && s.repeat_count[6:0] == 7'd0) begin
      res_valid_o = 1'b1;
      res_o.is_down = 1'b1;
      res_o.event_kind = kind_of(s.press_status);
      if (s.repeat_count == 8'd0) begin
        s.repeat_count = {1'b1, cfg_i.hold_start_delay};
        res_o.hold_seconds = 6'd0;
        s.press_status = bpdh_pkg::PS_HOLD;
        s.hold_quarters = bpdh_pkg::FirstHoldQuarters;
      end else begin
        s.repeat_count = {1'b1, cfg_i.hold_repeat_period};
        if (s.hold_quarters < bpdh_pkg::HoldQuartersMax) begin
          s.hold_quarters = s.hold_quarters + 8'd1;
        end
        res_o.hold_seconds = s.hold_quarters[7:2];
        if (in_i.consumer_ack) s.press_status = bpdh_pkg::PS_HOLD_ACKED;
      end
    end

    st_o = s;
  end

endmodule

// ----- design/bpdh_checker.sv -----
// ----------------------------------------------------------------------------
// bpdh_checker
// Port-level checks on the detector, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bpdh_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bpdh_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output item changed.");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled without a waiting output item.");

  a_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.is_down)
    else $error("Output item given while the button is up.");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_kind == bpdh_pkg::EV_PRESS ||
                    out_data_o.event_kind == bpdh_pkg::EV_DOUBLE)
      |-> out_data_o.hold_seconds == 6'd0)
    else $error("First event carries a hold time.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_kind == bpdh_pkg::EV_HOLD ||
                    out_data_o.event_kind == bpdh_pkg::EV_HOLD_ACKED)
      |-> out_data_o.hold_seconds != 6'd0)
    else $error("Hold event carries no hold time.");

endmodule

bind button_press_double_hold_detector_core bpdh_checker u_bpdh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- dv/tb_button_press_double_hold_detector_core.sv -----
// ----------------------------------------------------------------------------
// tb_button_press_double_hold_detector_core
// Self-checking bench for the button press, double press and hold detector.
// Tick items are driven in random bursts while the result side stalls on a
// pattern of its own. A scoreboard class tracks debounce, double press window
// and hold timing and compares every result field with its own prediction.
// The run steps through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_button_press_double_hold_detector_core;

  class bpdh_scoreboard;
    bpdh_pkg::cfg_t        cfg;
    logic [7:0]            deb_cnt;
    logic [7:0]            rpt_cnt;
    logic [7:0]            dbl_timer;
    logic [7:0]            quarters;
    bpdh_pkg::event_kind_e status;
    logic                  down;
    logic                  dbl_armed;
    bpdh_pkg::out_t        expected_q[$];
    int                    n_errors;
    int                    n_ticks;
    int                    kind_seen[4];
    int                    max_seconds;

    function new();
      cfg = '{idle_level: 1'b1, debounce_ticks: 7'd2, first_event_delay: 7'd5,
              hold_start_delay: 7'd100, hold_repeat_period: 7'd25,
              double_window: 8'd30};
      deb_cnt   = '0;
      rpt_cnt   = '0;
      dbl_timer = '0;
      quarters  = '0;
      status    = bpdh_pkg::EV_PRESS;
      down      = 1'b0;
      dbl_armed = 1'b0;
      n_errors  = 0;
      n_ticks   = 0;
      max_seconds = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void write_reg(logic [bpdh_pkg::CfgIdxW-1:0] idx,
                            logic [bpdh_pkg::CfgDataW-1:0] v);
      case (idx)
        bpdh_pkg::CFG_IDLE_LEVEL:    cfg.idle_level = v[0];
        bpdh_pkg::CFG_DEBOUNCE:      cfg.debounce_ticks = v[6:0];
        bpdh_pkg::CFG_FIRST_DELAY:   cfg.first_event_delay = v[6:0];
        bpdh_pkg::CFG_HOLD_START:    cfg.hold_start_delay = v[6:0];
        bpdh_pkg::CFG_HOLD_REPEAT:   cfg.hold_repeat_period = v[6:0];
        bpdh_pkg::CFG_DOUBLE_WINDOW: cfg.double_window = v;
        default: ;
      endcase
    endfunction

    function void note_tick(bpdh_pkg::in_t t);
      bpdh_pkg::out_t e;
      n_ticks++;
      if (deb_cnt[6:0] != 0) deb_cnt--;
      if (rpt_cnt[6:0] != 0) rpt_cnt--;
      if (dbl_timer != 0) dbl_timer--;
      else dbl_armed = 1'b0;
      if (t.pin_level != cfg.idle_level) begin
        if (deb_cnt == 0) begin
          deb_cnt = {1'b1, cfg.debounce_ticks};
        end else if (deb_cnt == 8'h80 && !down) begin
          down = 1'b1;
          if (!dbl_armed || dbl_timer == 0) begin
            dbl_armed = 1'b1;
            status    = bpdh_pkg::EV_PRESS;
            dbl_timer = cfg.double_window;
          end else begin
            status    = bpdh_pkg::EV_DOUBLE;
            dbl_armed = 1'b0;
          end
          rpt_cnt  = {1'b0, cfg.first_event_delay};
          quarters = '0;
        end
      end else if (down) begin
        deb_cnt = '0;
        rpt_cnt = '0;
        down    = 1'b0;
      end
      if (!down || rpt_cnt[6:0] != 0) return;
      e.is_down    = 1'b1;
      e.event_kind = status;
      if (rpt_cnt == 0) begin
        rpt_cnt        = {1'b1, cfg.hold_start_delay};
        e.hold_seconds = '0;
        status         = bpdh_pkg::EV_HOLD;
        quarters       = bpdh_pkg::FirstHoldQuarters;
      end else begin
        rpt_cnt = {1'b1, cfg.hold_repeat_period};
        if (quarters != bpdh_pkg::HoldQuartersMax) quarters++;
        e.hold_seconds = quarters[7:2];
        if (t.consumer_ack) status = bpdh_pkg::EV_HOLD_ACKED;
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(bpdh_pkg::out_t got);
      bpdh_pkg::out_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        n_errors++;
        return;
      end
      w = expected_q.pop_front();
      if (got.event_kind !== w.event_kind) begin
        $display("%0t: event_kind expected %0d, got %0d", $time, w.event_kind,
                 got.event_kind);
        n_errors++;
      end
      if (got.hold_seconds !== w.hold_seconds) begin
        $display("%0t: hold_seconds expected %0d, got %0d", $time, w.hold_seconds,
                 got.hold_seconds);
        n_errors++;
      end
      if (got.is_down !== w.is_down) begin
        $display("%0t: is_down expected %0d, got %0d", $time, w.is_down,
                 got.is_down);
        n_errors++;
      end
      kind_seen[w.event_kind]++;
      if (w.hold_seconds > max_seconds) max_seconds = w.hold_seconds;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_e;

  localparam logic [1:0] DirSeq [18] = '{
    2'b10, 2'b00, 2'b11, 2'b10, 2'b10, 2'b01, 2'b00, 2'b01, 2'b00,
    2'b10, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b01, 2'b11, 2'b10
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [bpdh_pkg::CfgIdxW-1:0]   cfg_idx = '0;
  logic [bpdh_pkg::CfgDataW-1:0]  cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  bpdh_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  bpdh_pkg::out_t                 out_data;

  bpdh_scoreboard        sb;
  int                    burst_left = 0;
  int                    phase_left = 0;
  int                    n_settings = 0;
  rx_mode_e              rx_mode = RX_FREE;
  int                    rx_cnt = 0;

  button_press_double_hold_detector_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rx_cnt++;
    if (rx_cnt % 50 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
      default:   out_ready <= (rx_cnt % 4 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic push_tick(logic pin, logic ack);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{pin_level: pin, consumer_ack: ack};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_tick(in_data);
    phase_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bpdh_pkg::CfgIdxW-1:0] idx,
                           logic [bpdh_pkg::CfgDataW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
  endtask

  task automatic apply_cfg(logic idle, logic [6:0] deb, logic [6:0] first,
                           logic [6:0] hold, logic [6:0] rep, logic [7:0] win);
    drain();
    write_reg(bpdh_pkg::CFG_IDLE_LEVEL, {7'd0, idle});
    write_reg(bpdh_pkg::CFG_DEBOUNCE, {1'b0, deb});
    write_reg(bpdh_pkg::CFG_FIRST_DELAY, {1'b0, first});
    write_reg(bpdh_pkg::CFG_HOLD_START, {1'b0, hold});
    write_reg(bpdh_pkg::CFG_HOLD_REPEAT, {1'b0, rep});
    write_reg(bpdh_pkg::CFG_DOUBLE_WINDOW, win);
    write_reg(bpdh_pkg::CFG_DOUBLE_WINDOW + 3'd1, 8'($urandom()));
    write_reg(bpdh_pkg::CFG_DOUBLE_WINDOW + 3'd2, 8'($urandom()));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic hold_level(logic level, int len);
    for (int i = 0; i < len && phase_left > 0; i++) begin
      push_tick(level, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int budget, int forced);
    logic pressed;
    int   len;
    int   base;
    int   r;
    phase_left = budget;
    pressed = !sb.cfg.idle_level;
    if (forced > 0) begin
      hold_level(pressed, forced);
      hold_level(!pressed, 3);
    end
    while (phase_left > 0) begin
      r = $urandom_range(0, 99);
      base = sb.cfg.debounce_ticks + sb.cfg.first_event_delay + 1;
      if (r < 12) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len && phase_left > 0; i++) begin
          push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else if (r < 24) begin
        hold_level(pressed, $urandom_range(1, sb.cfg.debounce_ticks + 1));
        hold_level(!pressed, $urandom_range(1, 3));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          len = base + sb.cfg.hold_start_delay
                + sb.cfg.hold_repeat_period * $urandom_range(0, 3)
                + $urandom_range(1, 3);
        end else begin
          len = $urandom_range(1, base + 2);
        end
        hold_level(pressed, len);
        if ($urandom_range(0, 1) == 0) hold_level(!pressed, $urandom_range(1, 4));
        else hold_level(!pressed, $urandom_range(1, sb.cfg.double_window + 10));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short walk through a press with a brief release inside its debounce, hold,
    // acknowledge and a second press after the double window with fast timing.
    apply_cfg(1'b1, 7'd2, 7'd0, 7'd0, 7'd1, 8'd6);
    phase_left = $size(DirSeq);
    foreach (DirSeq[i]) push_tick(DirSeq[i][1], DirSeq[i][0]);

    apply_cfg(1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 8'd0);
    run_phase(260, 258);
    apply_cfg(1'b1, 7'd127, 7'd0, 7'd127, 7'd127, 8'd255);
    run_phase(260, 258);
    apply_cfg(1'b0, 7'd0, 7'd127, 7'd0, 7'd1, 8'd1);
    run_phase(136, 133);
    repeat (3) begin
      apply_cfg(1'($urandom_range(0, 1)), 7'($urandom_range(0, 6)),
                7'($urandom_range(0, 8)), 7'($urandom_range(0, 20)),
                7'($urandom_range(0, 8)), 8'($urandom_range(0, 40)));
      run_phase(20, 0);
    end
    apply_cfg(1'b1, 7'd2, 7'd5, 7'd100, 7'd25, 8'd30);
    run_phase(20, 0);
    drain();

    $display("Drove %0d tick items through %0d register settings.", sb.n_ticks,
             n_settings);
    $display("Saw %0d press, %0d double, %0d hold, %0d acknowledged hold; max hold %0d s.",
             sb.kind_seen[bpdh_pkg::EV_PRESS], sb.kind_seen[bpdh_pkg::EV_DOUBLE],
             sb.kind_seen[bpdh_pkg::EV_HOLD], sb.kind_seen[bpdh_pkg::EV_HOLD_ACKED],
             sb.max_seconds);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for the block.");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
design/bpdh_pkg.sv
design/bpdh_step.sv
design/button_press_double_hold_detector_core.sv
design/bpdh_checker.sv
dv/tb_button_press_double_hold_detector_core.sv
